// File: rtl/tpg_pkg.sv
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared types, constants and helpers of the trapezoidal profile generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = 32;
    localparam int LIM_W       = 31;
    localparam int STEP_W      = 16;
    localparam int CFG_W       = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int PROD_W      = 64;
    localparam int DIVIDEND_W  = 64;
    localparam int DIVISOR_W   = 32;
    localparam int OFF_W       = 50;
    localparam int SUM_W       = OFF_W + 2;

    localparam logic [LIM_W-1:0]  MAX_VEL_RESET  = LIM_W'(65536);
    localparam logic [LIM_W-1:0]  MAX_ACC_RESET  = LIM_W'(65536);
    localparam logic [STEP_W-1:0] TIME_STEP_RESET = STEP_W'(655);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VEL   = 2'd0,
        CFG_MAX_ACC   = 2'd1,
        CFG_TIME_STEP = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        REQ_MOVE = 1'b0,
        REQ_TICK = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic                    req_type;
        logic signed [POS_W-1:0] start_position;
        logic signed [POS_W-1:0] goal_position;
    } req_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_M_MUL1,
        ST_M_MUL2,
        ST_M_CMP,
        ST_M_SQRT,
        ST_M_PSQ,
        ST_M_DIV1,
        ST_M_W1,
        ST_M_W2,
        ST_M_W3,
        ST_M_TOT,
        ST_M_FIN,
        ST_T_ADV,
        ST_E_SEL,
        ST_E_A1,
        ST_E_A2,
        ST_E_A3,
        ST_E_A4,
        ST_E_C1,
        ST_E_C2,
        ST_E_D1,
        ST_E_D2,
        ST_E_D3,
        ST_E_D4,
        ST_E_D5,
        ST_E_D6,
        ST_E_OUT
    } eng_state_t;

    typedef enum logic [1:0] {
        EM_LAST,
        EM_ACCEL,
        EM_CRUISE,
        EM_DECEL
    } emit_kind_t;

    function automatic logic [31:0] sat_u32(input logic [PROD_W-1:0] v);
        logic [31:0] r;
        r = (v > PROD_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/trapezoidal_profile_generator_unit.sv
// Timing: a tick word goes from the queue to the output register; a move word
// also waits on the radix-2 divider (up to three 64-bit divides) and, for
// triangular moves, on the integer square root.
// Throughput: one word at a time in the back end; the two-entry queue keeps
// taking words while a move is worked out or a point waits at the output.
// Reset: limits return to their defaults, the axis idles at goal 0, finished.
// ----------------------------------------------------------------------------
// trapezoidal_profile_generator_unit
// Single-axis trapezoidal velocity profile generator, Q16.16 fixed point.
// ----------------------------------------------------------------------------
module trapezoidal_profile_generator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpg_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic signed [tpg_pkg::POS_W-1:0]  start_position,
    input  logic signed [tpg_pkg::POS_W-1:0]  goal_position,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [31:0]                       point_time,
    output logic signed [tpg_pkg::POS_W-1:0]  position,
    output logic signed [31:0]                velocity,
    output logic signed [31:0]                acceleration,
    output logic                              last,
    output logic                              triangular
);
    import tpg_pkg::*;

    logic [LIM_W-1:0]  max_vel_reg;
    logic [LIM_W-1:0]  max_acc_reg;
    logic [STEP_W-1:0] step_reg;
    req_t              q_item;
    logic              q_valid;
    logic              q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vel_reg <= MAX_VEL_RESET;
            max_acc_reg <= MAX_ACC_RESET;
            step_reg    <= TIME_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_VEL:   max_vel_reg <= cfg_data[LIM_W-1:0];
                CFG_MAX_ACC:   max_acc_reg <= cfg_data[LIM_W-1:0];
                CFG_TIME_STEP: step_reg    <= cfg_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tpg_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .start_position (start_position),
        .goal_position  (goal_position),
        .q_item         (q_item),
        .q_valid        (q_valid),
        .q_pop          (q_pop)
    );

    tpg_engine u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .vel_limit        (max_vel_reg),
        .acc_limit        (max_acc_reg),
        .step_size        (step_reg),
        .q_item           (q_item),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .point_time       (point_time),
        .position         (position),
        .velocity         (velocity),
        .acceleration     (acceleration),
        .last             (last),
        .triangular       (triangular)
    );

endmodule

// File: rtl/tpg_front.sv
// ----------------------------------------------------------------------------
// tpg_front
// Request intake: takes input words and holds them in a short queue.
// ----------------------------------------------------------------------------
module tpg_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic signed [tpg_pkg::POS_W-1:0] start_position,
    input  logic signed [tpg_pkg::POS_W-1:0] goal_position,
    output tpg_pkg::req_t                   q_item,
    output logic                            q_valid,
    input  logic                            q_pop
);
    import tpg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{req_type, start_position, goal_position};
        end
    end

endmodule

// File: rtl/tpg_div.sv
// ----------------------------------------------------------------------------
// tpg_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpg_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tpg_pkg::div_req_t                   req,
    output logic                                busy,
    output logic                                done,
    output logic [tpg_pkg::DIVIDEND_W-1:0]      quotient
);
    import tpg_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  ge;
    logic [DIVISOR_W:0]    diff;

    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign diff     = trial - {1'b0, dvs_reg};
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

endmodule

// File: rtl/tpg_sqrt.sv
// ----------------------------------------------------------------------------
// tpg_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tpg_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tpg_pkg::PROD_W-1:0]      radicand,
    output logic                            busy,
    output logic                            done,
    output logic [tpg_pkg::PROD_W/2-1:0]    root
);
    import tpg_pkg::*;

    localparam int ITER  = PROD_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic [PROD_W-1:0] n_reg;
    logic [PROD_W-1:0] root_reg;
    logic [PROD_W-1:0] bit_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PROD_W-1:0] trial;
    logic              ge;

    assign trial = root_reg + bit_reg;
    assign ge    = (n_reg >= trial);
    assign busy  = busy_reg;
    assign done  = done_reg;
    assign root  = root_reg[PROD_W/2-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ITER - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= radicand;
            root_reg <= '0;
            bit_reg  <= PROD_W'(1) << (PROD_W - 2);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                n_reg    <= n_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

// File: rtl/tpg_engine.sv
// ----------------------------------------------------------------------------
// tpg_engine
// Back end: move planning, tick stepping and point output register.
// ----------------------------------------------------------------------------
module tpg_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [tpg_pkg::LIM_W-1:0]        vel_limit,
    input  logic [tpg_pkg::LIM_W-1:0]        acc_limit,
    input  logic [tpg_pkg::STEP_W-1:0]       step_size,
    input  tpg_pkg::req_t                    q_item,
    input  logic                             q_valid,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [31:0]                      point_time,
    output logic signed [tpg_pkg::POS_W-1:0] position,
    output logic signed [31:0]               velocity,
    output logic signed [31:0]               acceleration,
    output logic                             last,
    output logic                             triangular
);
    import tpg_pkg::*;

    eng_state_t state_reg, state_next;
    emit_kind_t kind_reg, kind_next;

    logic signed [POS_W-1:0] start_reg, goal_reg;
    logic                    neg_reg, finished_reg, tri_reg;
    logic [31:0]             dist_reg;
    logic [LIM_W-1:0]        macc_reg, peak_reg, v_reg, velmag_reg;
    logic [31:0]             ta_reg, tc_reg, ad_reg, cd_reg, total_reg, elapsed_reg, d_reg;
    logic [PROD_W-1:0]       da_reg, prod_reg;
    logic [OFF_W-1:0]        off_reg;

    logic                    out_valid_reg;
    logic [31:0]             o_time_reg;
    logic signed [31:0]      o_pos_reg, o_vel_reg, o_acc_reg;
    logic                    o_last_reg, o_tri_reg;

    logic [LIM_W-1:0]        a_eff, v_eff;
    logic [STEP_W-1:0]       step_eff;
    logic [31:0]             mul_a, mul_b;
    logic [PROD_W-1:0]       prod_shift, prod_shift1;
    logic                    load_out;

    div_req_t                div_req;
    logic                    div_busy, div_done;
    logic [DIVIDEND_W-1:0]   div_q;
    logic                    sqrt_start, sqrt_busy, sqrt_done;
    logic [PROD_W/2-1:0]     sqrt_root;

    logic signed [POS_W:0]   diff33;
    logic [32:0]             tsum, tcl_step, tatc;
    logic [31:0]             tcl;
    logic [31:0]             cd_calc;
    logic [33:0]             total_sum;
    logic signed [SUM_W-1:0] pos_sum;
    logic signed [31:0]      pos_sat;
    logic signed [31:0]      vel_s, acc_s;

    assign a_eff    = (acc_limit == '0) ? LIM_W'(1) : acc_limit;
    assign v_eff    = (vel_limit == '0) ? LIM_W'(1) : vel_limit;
    assign step_eff = (step_size == '0) ? STEP_W'(1) : step_size;

    assign prod_shift  = prod_reg >> FRAC_BITS;
    assign prod_shift1 = prod_reg >> (FRAC_BITS + 1);
    assign diff33   = $signed({q_item.goal_position[POS_W-1], q_item.goal_position})
                    - $signed({q_item.start_position[POS_W-1], q_item.start_position});
    assign tsum     = {1'b0, elapsed_reg} + 33'(step_eff);
    assign tcl      = (tsum > {1'b0, total_reg}) ? total_reg : tsum[31:0];
    assign tcl_step = {1'b0, tcl} + 33'(step_eff);
    assign tatc     = {1'b0, ta_reg} + {1'b0, tc_reg};
    assign cd_calc  = dist_reg - {ad_reg[30:0], 1'b0};
    assign total_sum = {1'b0, ta_reg, 1'b0} + {2'b00, tc_reg};

    // shared multiplier, product registered
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // final position with saturation, signed velocity and acceleration
    always_comb
    begin
        pos_sum = SUM_W'(start_reg)
                + (neg_reg ? -$signed(SUM_W'(off_reg)) : $signed(SUM_W'(off_reg)));
        if (pos_sum > $signed(SUM_W'(32'sh7FFF_FFFF)))
        begin
            pos_sat = 32'sh7FFF_FFFF;
        end
        else if (pos_sum < -$signed(SUM_W'(33'h0_8000_0000)))
        begin
            pos_sat = 32'sh8000_0000;
        end
        else
        begin
            pos_sat = pos_sum[31:0];
        end
        vel_s = neg_reg ? -$signed({1'b0, velmag_reg}) : $signed({1'b0, velmag_reg});
        case (kind_reg)
            EM_ACCEL:  acc_s = neg_reg ? -$signed({1'b0, macc_reg}) : $signed({1'b0, macc_reg});
            EM_DECEL:  acc_s = neg_reg ? $signed({1'b0, macc_reg}) : -$signed({1'b0, macc_reg});
            default:   acc_s = '0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        q_pop        = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_req      = '{1'b0, '0, '0};
        sqrt_start   = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = (q_item.req_type == REQ_MOVE) ? ST_M_MUL1 : ST_T_ADV;
                end
            end
            ST_M_MUL1:
            begin
                mul_a      = dist_reg;
                mul_b      = 32'(macc_reg);
                state_next = ST_M_MUL2;
            end
            ST_M_MUL2:
            begin
                mul_a      = 32'(v_eff);
                mul_b      = 32'(v_eff);
                state_next = ST_M_CMP;
            end
            ST_M_CMP:
            begin
                if (da_reg < prod_reg)
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_M_SQRT;
                end
                else
                begin
                    state_next = ST_M_PSQ;
                end
            end
            ST_M_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_M_PSQ;
                end
            end
            ST_M_PSQ:
            begin
                mul_a      = 32'(peak_reg);
                mul_b      = 32'(peak_reg);
                state_next = ST_M_DIV1;
            end
            ST_M_DIV1:
            begin
                div_req    = '{1'b1, prod_reg, {macc_reg, 1'b0}};
                state_next = ST_M_W1;
            end
            ST_M_W1:
            begin
                if (div_done)
                begin
                    div_req    = '{1'b1, DIVIDEND_W'(peak_reg) << FRAC_BITS, 32'(macc_reg)};
                    state_next = ST_M_W2;
                end
            end
            ST_M_W2:
            begin
                if (div_done)
                begin
                    if (peak_reg == '0)
                    begin
                        state_next = ST_M_TOT;
                    end
                    else
                    begin
                        div_req    = '{1'b1, DIVIDEND_W'(cd_calc) << FRAC_BITS,
                                       32'(peak_reg)};
                        state_next = ST_M_W3;
                    end
                end
            end
            ST_M_W3:
            begin
                if (div_done)
                begin
                    state_next = ST_M_TOT;
                end
            end
            ST_M_TOT:
            begin
                state_next = ST_M_FIN;
            end
            ST_M_FIN:
            begin
                state_next = ST_E_SEL;
            end
            ST_T_ADV:
            begin
                state_next = ST_E_SEL;
            end
            ST_E_SEL:
            begin
                if (finished_reg)
                begin
                    kind_next  = EM_LAST;
                    state_next = ST_E_OUT;
                end
                else if (elapsed_reg <= ta_reg)
                begin
                    kind_next  = EM_ACCEL;
                    state_next = ST_E_A1;
                end
                else if ({1'b0, elapsed_reg} <= tatc)
                begin
                    kind_next  = EM_CRUISE;
                    state_next = ST_E_C1;
                end
                else
                begin
                    kind_next  = EM_DECEL;
                    state_next = ST_E_D1;
                end
            end
            ST_E_A1:
            begin
                mul_a      = 32'(macc_reg);
                mul_b      = d_reg;
                state_next = ST_E_A2;
            end
            ST_E_A2:
            begin
                state_next = ST_E_A3;
            end
            ST_E_A3:
            begin
                mul_a      = 32'(v_reg);
                mul_b      = d_reg;
                state_next = ST_E_A4;
            end
            ST_E_A4:
            begin
                state_next = ST_E_OUT;
            end
            ST_E_C1:
            begin
                mul_a      = 32'(peak_reg);
                mul_b      = d_reg;
                state_next = ST_E_C2;
            end
            ST_E_C2:
            begin
                state_next = ST_E_OUT;
            end
            ST_E_D1:
            begin
                mul_a      = 32'(macc_reg);
                mul_b      = d_reg;
                state_next = ST_E_D2;
            end
            ST_E_D2:
            begin
                state_next = ST_E_D3;
            end
            ST_E_D3:
            begin
                mul_a      = 32'(peak_reg);
                mul_b      = d_reg;
                state_next = ST_E_D4;
            end
            ST_E_D4:
            begin
                state_next = ST_E_D5;
            end
            ST_E_D5:
            begin
                mul_a      = 32'(v_reg);
                mul_b      = d_reg;
                state_next = ST_E_D6;
            end
            ST_E_D6:
            begin
                state_next = ST_E_OUT;
            end
            ST_E_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= EM_LAST;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            goal_reg      <= '0;
            neg_reg       <= 1'b0;
            tri_reg       <= 1'b0;
            finished_reg  <= 1'b1;
            macc_reg      <= '0;
            peak_reg      <= '0;
            ta_reg        <= '0;
            tc_reg        <= '0;
            ad_reg        <= '0;
            cd_reg        <= '0;
            total_reg     <= '0;
            elapsed_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_item.req_type == REQ_MOVE)
                    begin
                        start_reg <= q_item.start_position;
                        goal_reg  <= q_item.goal_position;
                        neg_reg   <= diff33 < 0;
                        macc_reg  <= a_eff;
                    end
                end
                ST_M_CMP:
                begin
                    tri_reg <= (da_reg < prod_reg);
                    if (!(da_reg < prod_reg))
                    begin
                        peak_reg <= v_eff;
                    end
                end
                ST_M_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        peak_reg <= sqrt_root[LIM_W-1:0];
                    end
                end
                ST_M_W1:
                begin
                    if (div_done)
                    begin
                        ad_reg <= div_q[31:0];
                    end
                end
                ST_M_W2:
                begin
                    if (div_done)
                    begin
                        ta_reg <= sat_u32(div_q);
                        cd_reg <= cd_calc;
                        tc_reg <= '0;
                    end
                end
                ST_M_W3:
                begin
                    if (div_done)
                    begin
                        tc_reg <= sat_u32(div_q);
                    end
                end
                ST_M_TOT:
                begin
                    total_reg   <= sat_u32(PROD_W'(total_sum));
                    elapsed_reg <= '0;
                end
                ST_M_FIN:
                begin
                    finished_reg <= (32'(step_eff) > total_reg);
                end
                ST_T_ADV:
                begin
                    if (!finished_reg)
                    begin
                        elapsed_reg  <= tcl;
                        finished_reg <= (tcl_step > {1'b0, total_reg});
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_item.req_type == REQ_MOVE)
                begin
                    dist_reg <= (diff33 < 0) ? 32'(-diff33) : diff33[31:0];
                end
            end
            ST_M_MUL2:
            begin
                da_reg <= prod_reg;
            end
            ST_E_SEL:
            begin
                if (elapsed_reg <= ta_reg)
                begin
                    d_reg <= elapsed_reg;
                end
                else if ({1'b0, elapsed_reg} <= tatc)
                begin
                    d_reg <= elapsed_reg - ta_reg;
                end
                else
                begin
                    d_reg <= elapsed_reg - tatc[31:0];
                end
            end
            ST_E_A2, ST_E_D2:
            begin
                v_reg <= (prod_shift > PROD_W'(peak_reg)) ? peak_reg : prod_shift[LIM_W-1:0];
            end
            ST_E_A4:
            begin
                off_reg    <= prod_shift1[OFF_W-1:0];
                velmag_reg <= v_reg;
            end
            ST_E_C2:
            begin
                off_reg    <= OFF_W'(ad_reg) + prod_shift[OFF_W-1:0];
                velmag_reg <= peak_reg;
            end
            ST_E_D4:
            begin
                off_reg <= OFF_W'(ad_reg) + OFF_W'(cd_reg) + prod_shift[OFF_W-1:0];
            end
            ST_E_D6:
            begin
                off_reg    <= off_reg - prod_shift1[OFF_W-1:0];
                velmag_reg <= peak_reg - v_reg;
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            o_time_reg <= elapsed_reg;
            o_tri_reg  <= tri_reg;
            if (kind_reg == EM_LAST)
            begin
                o_pos_reg  <= goal_reg;
                o_vel_reg  <= '0;
                o_acc_reg  <= '0;
                o_last_reg <= 1'b1;
            end
            else
            begin
                o_pos_reg  <= pos_sat;
                o_vel_reg  <= vel_s;
                o_acc_reg  <= acc_s;
                o_last_reg <= 1'b0;
            end
        end
    end

    tpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    tpg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (da_reg),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign out_valid    = out_valid_reg;
    assign point_time   = o_time_reg;
    assign position     = o_pos_reg;
    assign velocity     = o_vel_reg;
    assign acceleration = o_acc_reg;
    assign last         = o_last_reg;
    assign triangular   = o_tri_reg;

`ifndef SYNTHESIS
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    a_sqrt_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("square root started while busy");

    a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_reg <= total_reg)
        else $error("elapsed time beyond move end");

    a_last_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_last_reg) |-> (o_vel_reg == 0 && o_acc_reg == 0))
        else $error("last point not at rest");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != ST_IDLE))
        else $error("popped word not taken up");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trapezoidal profile generator: directed moves
// and ticks, then random move/tick sequences over several limit settings,
// each output point checked against an in-bench fixed point profile model.
// ----------------------------------------------------------------------------
module testbench;
    import tpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET    = 1000;

    typedef struct {
        logic [31:0]        t;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic               last;
        logic               tri_mode;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic req_type = 1'b0;
    logic signed [POS_W-1:0] start_position = '0;
    logic signed [POS_W-1:0] goal_position = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] point_time;
    logic signed [POS_W-1:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic last;
    logic triangular;

    trapezoidal_profile_generator_unit dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // profile model state
    longint unsigned lim_vel, lim_acc, step_reg;
    longint signed   mv_start, mv_goal;
    bit              mv_neg, mv_done, mv_tri;
    longint unsigned mv_acc, mv_peak, t_accel, t_cruise, d_accel, d_cruise, t_total, t_now;

    point_t pending_points[$];
    int     mismatches = 0;
    int     items_sent = 0;
    int     points_seen = 0;
    int     moves_sent = 0;
    int     idle_cycles = 0;
    bit     quiet = 1'b0;

    function automatic longint unsigned cap32(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic longint signed clamp32(longint signed v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    function automatic point_t profile_point(longint unsigned t, bit fin);
        point_t pt;
        longint signed off, vel, acc;
        longint unsigned v, d, dv;
        pt.t = t[31:0];
        pt.tri_mode = mv_tri;
        pt.last = fin;
        if (fin)
        begin
            pt.pos = mv_goal[31:0];
            pt.vel = 0;
            pt.acc = 0;
            return pt;
        end
        if (t <= t_accel)
        begin
            v = (mv_acc * t) >> FRAC_BITS;
            if (v > mv_peak)
                v = mv_peak;
            off = longint'((v * t) >> (FRAC_BITS + 1));
            vel = longint'(v);
            acc = longint'(mv_acc);
        end
        else if (t <= t_accel + t_cruise)
        begin
            off = longint'(d_accel + ((mv_peak * (t - t_accel)) >> FRAC_BITS));
            vel = longint'(mv_peak);
            acc = 0;
        end
        else
        begin
            d = t - t_accel - t_cruise;
            dv = (mv_acc * d) >> FRAC_BITS;
            if (dv > mv_peak)
                dv = mv_peak;
            off = longint'(d_accel + d_cruise + ((mv_peak * d) >> FRAC_BITS))
                - longint'((dv * d) >> (FRAC_BITS + 1));
            vel = longint'(mv_peak - dv);
            acc = -longint'(mv_acc);
        end
        if (mv_neg)
        begin
            off = -off;
            vel = -vel;
            acc = -acc;
        end
        pt.pos = 32'(clamp32(mv_start + off));
        pt.vel = 32'(clamp32(vel));
        pt.acc = 32'(clamp32(acc));
        return pt;
    endfunction

    function automatic point_t next_point(logic kind, logic signed [31:0] s,
                                          logic signed [31:0] g);
        longint unsigned stp, a, v, span, p;
        longint unsigned t;
        stp = step_reg ? step_reg : 1;
        if (kind == REQ_MOVE)
        begin
            a = lim_acc ? lim_acc : 1;
            v = lim_vel ? lim_vel : 1;
            mv_start = 64'(s);
            mv_goal = 64'(g);
            mv_neg = mv_goal < mv_start;
            span = longint'(mv_neg ? mv_start - mv_goal : mv_goal - mv_start);
            mv_tri = span * a < v * v;
            p = mv_tri ? int_sqrt(span * a) : v;
            mv_acc = a;
            mv_peak = p;
            d_accel = (p * p) / (2 * a);
            t_accel = cap32((p << FRAC_BITS) / a);
            d_cruise = span - 2 * d_accel;
            t_cruise = p ? cap32((d_cruise << FRAC_BITS) / p) : 0;
            t_total = cap32(2 * t_accel + t_cruise);
            t_now = 0;
            mv_done = stp > t_total;
            return profile_point(0, mv_done);
        end
        if (!mv_done)
        begin
            t = t_now + stp;
            if (t > t_total)
                t = t_total;
            t_now = t;
            mv_done = t + stp > t_total;
        end
        return profile_point(t_now, mv_done);
    endfunction

    // ---------------- output side ----------------
    always @(negedge clk)
        out_ready = quiet || ($urandom_range(99) >= 9);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        point_t exp_pt;
        if (rst_n && out_valid && out_ready)
        begin
            points_seen++;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected point t=%h pos=%h", $time, point_time, position);
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                if (point_time !== exp_pt.t || position !== exp_pt.pos ||
                    velocity !== exp_pt.vel || acceleration !== exp_pt.acc ||
                    last !== exp_pt.last || triangular !== exp_pt.tri_mode)
                begin
                    mismatches++;
                    $display("%0t: mismatch exp t=%h pos=%h vel=%h acc=%h last=%b tri=%b",
                             $time, exp_pt.t, exp_pt.pos, exp_pt.vel, exp_pt.acc,
                             exp_pt.last, exp_pt.tri_mode);
                    $display("%0t:          act t=%h pos=%h vel=%h acc=%h last=%b tri=%b",
                             $time, point_time, position, velocity, acceleration,
                             last, triangular);
                end
            end
        end
    end

    // ---------------- input side ----------------
    task automatic send_word(logic kind, logic signed [31:0] s, logic signed [31:0] g);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 9)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = kind;
        start_position = s;
        goal_position = g;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        pending_points.insert(pending_points.size(), next_point(kind, s, g));
        items_sent++;
        if (kind == REQ_MOVE)
            moves_sent++;
    endtask

    task automatic send_move(logic signed [31:0] s, logic signed [31:0] g);
        send_word(REQ_MOVE, s, g);
    endtask

    task automatic send_ticks(int n);
        repeat (n)
            send_word(REQ_TICK, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (260)
            @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            CFG_MAX_VEL:   lim_vel = 64'(value);
            CFG_MAX_ACC:   lim_acc = 64'(value);
            CFG_TIME_STEP: step_reg = 64'(value[STEP_W-1:0]);
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_limits(logic [30:0] v, logic [30:0] a, logic [15:0] stp);
        wait_idle();
        cfg_write(CFG_MAX_VEL, v);
        cfg_write(CFG_MAX_ACC, a);
        cfg_write(CFG_TIME_STEP, CFG_W'(stp));
    endtask

    // ---------------- tests ----------------
    task automatic test_after_reset();
        send_ticks(2);
        send_move(32'sh0001_0000, 32'sh0001_0000);
        send_ticks(1);
    endtask

    task automatic test_extremes();
        send_move(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_ticks(2);
        send_move(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_ticks(2);
        set_limits(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
        send_move(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_ticks(2);
        set_limits(31'd1, 31'd1, 16'd1);
        send_move(32'sh0000_0000, 32'sh0000_0000);
        send_move(32'sh0000_0000, 32'sh0000_0005);
        send_ticks(2);
    endtask

    task automatic test_zero_regs();
        set_limits(31'd0, 31'd0, 16'd0);
        send_move(32'sh0000_0010, 32'sh0000_0000);
        send_ticks(2);
    endtask

    task automatic test_triangular_and_grown_step();
        set_limits(31'h0004_0000, 31'h0002_0000, 16'h2000);
        send_move(32'sh0000_0000, 32'sh0000_8000);  // short: triangular
        send_ticks(8);
        send_move(32'sh0010_0000, 32'sh0000_0000);  // reverse trapezoid
        send_ticks(3);
        wait_idle();
        cfg_write(CFG_TIME_STEP, CFG_W'(16'hFFFF));
        send_ticks(3);
    endtask

    task automatic test_random_moves(int phases);
        int n, bits;
        logic signed [31:0] s, g;
        longint signed gl;
        for (int ph = 0; ph < phases; ph++)
        begin
            if (items_sent >= ITEM_TARGET)
                break;
            case ($urandom_range(5))
                0: set_limits(31'h7FFF_FFFF, 31'($urandom_range(1, 32'h0010_0000)),
                              16'($urandom_range(4096, 65535)));
                1: set_limits(31'($urandom_range(1, 32'h0001_0000)), 31'h7FFF_FFFF,
                              16'($urandom_range(1, 65535)));
                default: set_limits(31'($urandom_range(1, 32'h0010_0000)),
                                    31'($urandom_range(1, 32'h0010_0000)),
                                    16'($urandom_range(8192, 65535)));
            endcase
            quiet = (ph == 2);
            repeat (8)
            begin
                if (items_sent >= ITEM_TARGET)
                    break;
                s = $urandom;
                if ($urandom_range(9) == 0)
                    g = $urandom;
                else
                begin
                    bits = $urandom_range(0, 24);
                    gl = longint'(s) + (($urandom_range(1) ? 1 : -1) *
                         longint'($urandom & ((32'd1 << bits) - 1)));
                    g = 32'(clamp32(gl));
                end
                send_move(s, g);
                n = 0;
                while (!mv_done && n < 30)
                begin
                    send_ticks(1);
                    n++;
                    if ($urandom_range(49) == 0)
                        break;  // abandon the move midway
                end
                send_ticks($urandom_range(0, 2));
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        lim_vel = 65536;
        lim_acc = 65536;
        step_reg = 655;
        mv_start = 0;
        mv_goal = 0;
        mv_neg = 0;
        mv_acc = 0;
        mv_peak = 0;
        t_accel = 0;
        t_cruise = 0;
        d_accel = 0;
        d_cruise = 0;
        t_total = 0;
        t_now = 0;
        mv_done = 1;
        mv_tri = 0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_extremes();
        test_zero_regs();
        test_triangular_and_grown_step();
        while (items_sent < ITEM_TARGET)
            test_random_moves(4);

        wait_idle();
        $display("Covered %0d words (%0d moves), %0d points checked, %0d mismatches.",
                 items_sent, moves_sent, points_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tpg_pkg.sv
rtl/tpg_front.sv
rtl/tpg_div.sv
rtl/tpg_sqrt.sv
rtl/tpg_engine.sv
rtl/trapezoidal_profile_generator_unit.sv
test/testbench.sv
